// ===== design/linear_probe_hash_insert_assert.svh =====
// Assertion helpers used by the top-level design file.
`ifndef LINEAR_PROBE_HASH_INSERT_ASSERT_SVH
`define LINEAR_PROBE_HASH_INSERT_ASSERT_SVH

// Condition holds on every clock edge out of reset.
`define LPHI_ASSERT_ALWAYS(label, clk, rstn, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (cond)) else $error(msg);

// Same-cycle implication.
`define LPHI_ASSERT_IMPL(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define LPHI_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== design/lphi_pkg.sv =====
`timescale 1ns / 1ps

package lphi_pkg;

    localparam int KEY_W          = 31;
    localparam int SLOT_OUT_W     = 4;
    localparam int STATUS_W       = 2;
    localparam int TABLE_SIZE_DEF = 16;

    typedef enum logic {
        REQ_INSERT = 1'b0,
        REQ_READ   = 1'b1
    } req_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_INSERTED = 2'd0,
        ST_FULL     = 2'd1,
        ST_READ     = 2'd2
    } status_t;

endpackage

// ===== design/lphi_mod.sv =====
`timescale 1ns / 1ps

// key mod TABLE_SIZE by reciprocal multiplication, in registered steps:
// capture, quotient = (key * RECIP) >> SHIFT, remainder = key - quotient * size.
// Only the low slot bits of quotient and product are kept; the remainder is below the size.
module lphi_mod
    import lphi_pkg::*;
#(
    parameter int TABLE_SIZE = TABLE_SIZE_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          start,
    input  logic [KEY_W-1:0]              dividend,
    output logic                          done,
    output logic [$clog2(TABLE_SIZE)-1:0] remainder
);

    localparam int SLOT_W = $clog2(TABLE_SIZE);
    localparam int SHIFT  = KEY_W + SLOT_W;
    localparam int PROD_W = 2 * KEY_W + 1;
    // ceil(2^SHIFT / size): exact quotient for every key below 2^KEY_W
    localparam logic [KEY_W:0] RECIP =
        (KEY_W + 1)'(((64'd1 << SHIFT) + 64'(TABLE_SIZE) - 64'd1) / 64'(TABLE_SIZE));
    localparam logic [SLOT_W-1:0] DIV_LO = SLOT_W'(TABLE_SIZE);

    logic              key_vld_reg;
    logic              quo_vld_reg;
    logic              done_reg;
    logic [KEY_W-1:0]  key_reg;
    logic [SLOT_W-1:0] quo_lo_reg;
    logic [SLOT_W-1:0] rem_reg;
    logic [PROD_W-1:0] prod;

    assign prod = PROD_W'(key_reg) * PROD_W'(RECIP);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            key_vld_reg <= 1'b0;
            quo_vld_reg <= 1'b0;
            done_reg    <= 1'b0;
        end else begin
            key_vld_reg <= start;
            quo_vld_reg <= key_vld_reg;
            done_reg    <= quo_vld_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            key_reg <= dividend;
        end
        if (key_vld_reg) begin
            quo_lo_reg <= prod[SHIFT +: SLOT_W];
        end
        if (quo_vld_reg) begin
            rem_reg <= key_reg[SLOT_W-1:0] - SLOT_W'(quo_lo_reg * DIV_LO);
        end
    end

    assign done      = done_reg;
    assign remainder = rem_reg;

endmodule

// ===== design/lphi_table.sv =====
`timescale 1ns / 1ps

// One hash table: slot memory of {used, home, key}, registered read.
module lphi_table
    import lphi_pkg::*;
#(
    parameter int TABLE_SIZE = TABLE_SIZE_DEF
) (
    input  logic                          aclk,
    input  logic                          wr_en,
    input  logic [$clog2(TABLE_SIZE)-1:0] wr_addr,
    input  logic                          wr_used,
    input  logic [$clog2(TABLE_SIZE)-1:0] wr_home,
    input  logic [KEY_W-1:0]              wr_key,
    input  logic [$clog2(TABLE_SIZE)-1:0] rd_addr,
    output logic                          rd_used,
    output logic [$clog2(TABLE_SIZE)-1:0] rd_home,
    output logic [KEY_W-1:0]              rd_key
);

    localparam int SLOT_W = $clog2(TABLE_SIZE);
    localparam int WORD_W = 1 + SLOT_W + KEY_W;

    logic [WORD_W-1:0] mem [TABLE_SIZE];
    logic [WORD_W-1:0] rd_word_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= {wr_used, wr_home, wr_key};
        end
    end

    always_ff @(posedge aclk) begin
        rd_word_reg <= mem[rd_addr];
    end

    assign rd_used = rd_word_reg[WORD_W-1];
    assign rd_home = rd_word_reg[KEY_W +: SLOT_W];
    assign rd_key  = rd_word_reg[KEY_W-1:0];

endmodule

// ===== design/linear_probe_hash_insert.sv =====
// Insert: IDLE, MOD (home = key mod size, reciprocal multiply), PL_WAIT, PL_PROBE over
//   P plain slots (1..TABLE_SIZE), RP_WAIT, RP_HOME, RP_PROBE over R replacement slots
//   after home (0..TABLE_SIZE-1), DONE. Read: IDLE, RD_WAIT, DONE; refused insert (table
//   full): IDLE, DONE. One word in flight at a time; the result register lets the next
//   word enter while a result waits. Reset (aresetn, sync, active low): a clearing pass
//   over every slot empties both tables; s_ready stays low until it is done.
`timescale 1ns / 1ps
`include "linear_probe_hash_insert_assert.svh"

module linear_probe_hash_insert
    import lphi_pkg::*;
#(
    parameter int TABLE_SIZE = TABLE_SIZE_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    // request channel
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic                  s_req_type,
    input  logic [KEY_W-1:0]      s_key,
    input  logic [SLOT_OUT_W-1:0] s_slot_index,
    // result channel
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic [STATUS_W-1:0]   m_status,
    output logic [SLOT_OUT_W-1:0] m_plain_slot,
    output logic [SLOT_OUT_W-1:0] m_repl_slot,
    output logic                  m_displaced,
    output logic                  m_plain_valid,
    output logic [KEY_W-1:0]      m_plain_value,
    output logic                  m_repl_valid,
    output logic [KEY_W-1:0]      m_repl_value
);

    localparam int SLOT_W = $clog2(TABLE_SIZE);
    localparam int FILL_W = $clog2(TABLE_SIZE + 1);
    localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(TABLE_SIZE - 1);
    localparam logic [FILL_W-1:0] FULL_CNT  = FILL_W'(TABLE_SIZE);

    // Sequencer states:
    //   CLEAR     - post-reset sweep, marks every slot of both tables free
    //   MOD       - shared unit works out the home slot
    //   PL_*      - plain table probe (WAIT primes the read pipe)
    //   RP_HOME   - replacement table: decide keep / probe new key / displace
    //   RP_PROBE  - replacement table probe for the moving key
    //   DONE      - hand the result to the output register
    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_RD_WAIT,
        S_MOD,
        S_PL_WAIT,
        S_PL_PROBE,
        S_RP_WAIT,
        S_RP_HOME,
        S_RP_PROBE,
        S_DONE
    } state_t;

    state_t            state_reg, state_next;
    logic [SLOT_W-1:0] clr_cnt_reg, clr_cnt_next;
    logic [SLOT_W-1:0] addr_reg, addr_next;      // address read this cycle
    logic [SLOT_W-1:0] chk_addr_reg;             // address of the data now on rd_*
    logic [FILL_W-1:0] fill_count_reg, fill_count_next;
    logic [KEY_W-1:0]  key_reg, key_next;
    logic [SLOT_W-1:0] home_reg, home_next;
    logic [KEY_W-1:0]  mover_key_reg, mover_key_next;
    logic [SLOT_W-1:0] mover_home_reg, mover_home_next;
    logic [SLOT_W-1:0] ps_reg, ps_next;
    logic [SLOT_W-1:0] rs_reg, rs_next;
    logic              disp_reg, disp_next;
    logic              is_read_reg, is_read_next;
    logic              full_reg, full_next;
    logic              oor_reg, oor_next;

    // output register
    logic                  m_valid_reg, m_valid_next;
    status_t               m_status_reg, m_status_next;
    logic [SLOT_OUT_W-1:0] m_plain_slot_reg, m_plain_slot_next;
    logic [SLOT_OUT_W-1:0] m_repl_slot_reg, m_repl_slot_next;
    logic                  m_displaced_reg, m_displaced_next;
    logic                  m_plain_valid_reg, m_plain_valid_next;
    logic [KEY_W-1:0]      m_plain_value_reg, m_plain_value_next;
    logic                  m_repl_valid_reg, m_repl_valid_next;
    logic [KEY_W-1:0]      m_repl_value_reg, m_repl_value_next;

    // table ports
    logic              pl_wr_en, rp_wr_en;
    logic [SLOT_W-1:0] pl_wr_addr, rp_wr_addr;
    logic              tbl_wr_used;
    logic [SLOT_W-1:0] rp_wr_home;
    logic [KEY_W-1:0]  rp_wr_key;
    logic              pl_rd_used, rp_rd_used;
    logic [SLOT_W-1:0] pl_rd_home, rp_rd_home;
    logic [KEY_W-1:0]  pl_rd_key, rp_rd_key;

    // mod unit
    logic              mod_start;
    logic              mod_done;
    logic [SLOT_W-1:0] mod_rem;

    logic accept;
    logic out_free;
    logic pl_found, rp_found;
    logic home_foreign;

    assign accept       = s_valid && s_ready;
    assign out_free     = !m_valid_reg || m_ready;
    assign pl_found     = !pl_rd_used;
    assign rp_found     = !rp_rd_used;
    // occupant of home belongs to another home: it gets moved out
    assign home_foreign = rp_rd_used && (rp_rd_home != home_reg);
    assign mod_start    = accept && (s_req_type == REQ_INSERT) &&
                          (fill_count_reg != FULL_CNT);

    function automatic logic [SLOT_W-1:0] slot_inc(input logic [SLOT_W-1:0] s);
        slot_inc = (s == LAST_SLOT) ? '0 : s + 1'b1;
    endfunction

    lphi_mod #(
        .TABLE_SIZE (TABLE_SIZE)
    ) u_mod (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (mod_start),
        .dividend  (s_key),
        .done      (mod_done),
        .remainder (mod_rem)
    );

    // Plain table writes: clearing sweep, or the slot a probe just found free.
    assign tbl_wr_used = (state_reg != S_CLEAR);
    assign pl_wr_en    = (state_reg == S_CLEAR) || ((state_reg == S_PL_PROBE) && pl_found);
    assign pl_wr_addr  = (state_reg == S_CLEAR) ? clr_cnt_reg : chk_addr_reg;

    // Replacement table: new key into home if free or if the occupant is foreign,
    // then the mover (new key or evicted occupant) into the first free slot after home.
    assign rp_wr_en   = (state_reg == S_CLEAR) ||
                        ((state_reg == S_RP_HOME) && (rp_found || home_foreign)) ||
                        ((state_reg == S_RP_PROBE) && rp_found);
    assign rp_wr_addr = (state_reg == S_CLEAR) ? clr_cnt_reg : chk_addr_reg;
    assign rp_wr_home = (state_reg == S_RP_PROBE) ? mover_home_reg : home_reg;
    assign rp_wr_key  = (state_reg == S_RP_PROBE) ? mover_key_reg : key_reg;

    lphi_table #(
        .TABLE_SIZE (TABLE_SIZE)
    ) u_plain (
        .aclk    (aclk),
        .wr_en   (pl_wr_en),
        .wr_addr (pl_wr_addr),
        .wr_used (tbl_wr_used),
        .wr_home (home_reg),
        .wr_key  (key_reg),
        .rd_addr (addr_reg),
        .rd_used (pl_rd_used),
        .rd_home (pl_rd_home),
        .rd_key  (pl_rd_key)
    );

    lphi_table #(
        .TABLE_SIZE (TABLE_SIZE)
    ) u_repl (
        .aclk    (aclk),
        .wr_en   (rp_wr_en),
        .wr_addr (rp_wr_addr),
        .wr_used (tbl_wr_used),
        .wr_home (rp_wr_home),
        .wr_key  (rp_wr_key),
        .rd_addr (addr_reg),
        .rd_used (rp_rd_used),
        .rd_home (rp_rd_home),
        .rd_key  (rp_rd_key)
    );

    always_comb begin
        state_next         = state_reg;
        clr_cnt_next       = clr_cnt_reg;
        addr_next          = addr_reg;
        fill_count_next    = fill_count_reg;
        key_next           = key_reg;
        home_next          = home_reg;
        mover_key_next     = mover_key_reg;
        mover_home_next    = mover_home_reg;
        ps_next            = ps_reg;
        rs_next            = rs_reg;
        disp_next          = disp_reg;
        is_read_next       = is_read_reg;
        full_next          = full_reg;
        oor_next           = oor_reg;
        m_valid_next       = m_valid_reg && !m_ready;
        m_status_next      = m_status_reg;
        m_plain_slot_next  = m_plain_slot_reg;
        m_repl_slot_next   = m_repl_slot_reg;
        m_displaced_next   = m_displaced_reg;
        m_plain_valid_next = m_plain_valid_reg;
        m_plain_value_next = m_plain_value_reg;
        m_repl_valid_next  = m_repl_valid_reg;
        m_repl_value_next  = m_repl_value_reg;

        unique case (state_reg)
            S_CLEAR: begin
                clr_cnt_next = slot_inc(clr_cnt_reg);
                if (clr_cnt_reg == LAST_SLOT) begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE: begin
                if (accept) begin
                    key_next     = s_key;
                    disp_next    = 1'b0;
                    is_read_next = (s_req_type == REQ_READ);
                    full_next    = (fill_count_reg == FULL_CNT);
                    oor_next     = (32'(s_slot_index) >= 32'(TABLE_SIZE));
                    addr_next    = SLOT_W'(s_slot_index);
                    if (s_req_type == REQ_READ) begin
                        state_next = S_RD_WAIT;
                    end else if (fill_count_reg == FULL_CNT) begin
                        state_next = S_DONE;
                    end else begin
                        state_next = S_MOD;
                    end
                end
            end
            S_RD_WAIT: begin
                // addr_reg holds the slot; data shows up next cycle
                state_next = S_DONE;
            end
            S_MOD: begin
                if (mod_done) begin
                    home_next  = mod_rem;
                    addr_next  = mod_rem;
                    state_next = S_PL_WAIT;
                end
            end
            S_PL_WAIT: begin
                addr_next  = slot_inc(addr_reg);
                state_next = S_PL_PROBE;
            end
            S_PL_PROBE: begin
                if (pl_found) begin
                    ps_next    = chk_addr_reg;
                    addr_next  = home_reg;
                    state_next = S_RP_WAIT;
                end else begin
                    addr_next = slot_inc(addr_reg);
                end
            end
            S_RP_WAIT: begin
                addr_next  = slot_inc(addr_reg);
                state_next = S_RP_HOME;
            end
            S_RP_HOME: begin
                if (rp_found) begin
                    rs_next         = home_reg;
                    fill_count_next = fill_count_reg + 1'b1;
                    state_next      = S_DONE;
                end else begin
                    if (home_foreign) begin
                        mover_key_next  = rp_rd_key;
                        mover_home_next = rp_rd_home;
                        disp_next       = 1'b1;
                    end else begin
                        mover_key_next  = key_reg;
                        mover_home_next = home_reg;
                    end
                    addr_next  = slot_inc(addr_reg);
                    state_next = S_RP_PROBE;
                end
            end
            S_RP_PROBE: begin
                if (rp_found) begin
                    rs_next         = chk_addr_reg;
                    fill_count_next = fill_count_reg + 1'b1;
                    state_next      = S_DONE;
                end else begin
                    addr_next = slot_inc(addr_reg);
                end
            end
            S_DONE: begin
                if (out_free) begin
                    m_valid_next       = 1'b1;
                    m_plain_slot_next  = '0;
                    m_repl_slot_next   = '0;
                    m_displaced_next   = 1'b0;
                    m_plain_valid_next = 1'b0;
                    m_plain_value_next = '0;
                    m_repl_valid_next  = 1'b0;
                    m_repl_value_next  = '0;
                    if (is_read_reg) begin
                        m_status_next      = ST_READ;
                        m_plain_valid_next = pl_rd_used && !oor_reg;
                        m_repl_valid_next  = rp_rd_used && !oor_reg;
                        if (pl_rd_used && !oor_reg) begin
                            m_plain_value_next = pl_rd_key;
                        end
                        if (rp_rd_used && !oor_reg) begin
                            m_repl_value_next = rp_rd_key;
                        end
                    end else if (full_reg) begin
                        m_status_next = ST_FULL;
                    end else begin
                        m_status_next     = ST_INSERTED;
                        m_plain_slot_next = SLOT_OUT_W'(ps_reg);
                        m_repl_slot_next  = SLOT_OUT_W'(rs_reg);
                        m_displaced_next  = disp_reg;
                    end
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= S_CLEAR;
            clr_cnt_reg    <= '0;
            fill_count_reg <= '0;
            m_valid_reg    <= 1'b0;
        end else begin
            state_reg      <= state_next;
            clr_cnt_reg    <= clr_cnt_next;
            fill_count_reg <= fill_count_next;
            m_valid_reg    <= m_valid_next;
        end
    end

    // payload and datapath registers, no reset
    always_ff @(posedge aclk) begin
        addr_reg          <= addr_next;
        chk_addr_reg      <= addr_reg;
        key_reg           <= key_next;
        home_reg          <= home_next;
        mover_key_reg     <= mover_key_next;
        mover_home_reg    <= mover_home_next;
        ps_reg            <= ps_next;
        rs_reg            <= rs_next;
        disp_reg          <= disp_next;
        is_read_reg       <= is_read_next;
        full_reg          <= full_next;
        oor_reg           <= oor_next;
        m_status_reg      <= m_status_next;
        m_plain_slot_reg  <= m_plain_slot_next;
        m_repl_slot_reg   <= m_repl_slot_next;
        m_displaced_reg   <= m_displaced_next;
        m_plain_valid_reg <= m_plain_valid_next;
        m_plain_value_reg <= m_plain_value_next;
        m_repl_valid_reg  <= m_repl_valid_next;
        m_repl_value_reg  <= m_repl_value_next;
    end

    assign s_ready       = (state_reg == S_IDLE);
    assign m_valid       = m_valid_reg;
    assign m_status      = m_status_reg;
    assign m_plain_slot  = m_plain_slot_reg;
    assign m_repl_slot   = m_repl_slot_reg;
    assign m_displaced   = m_displaced_reg;
    assign m_plain_valid = m_plain_valid_reg;
    assign m_plain_value = m_plain_value_reg;
    assign m_repl_valid  = m_repl_valid_reg;
    assign m_repl_value  = m_repl_value_reg;

    // count of stored keys never passes the table size
    `LPHI_ASSERT_ALWAYS(a_fill_bound, aclk, aresetn, fill_count_reg <= FULL_CNT, "fill count overflow")

    // a refused word only leaves when the table really is full
    `LPHI_ASSERT_IMPL(a_full_status, aclk, aresetn, m_valid_reg && (m_status_reg == ST_FULL), fill_count_reg == FULL_CNT, "full status with free room")

    // the mod unit only reports while the sequencer waits for it
    `LPHI_ASSERT_IMPL(a_mod_sync, aclk, aresetn, mod_done, state_reg == S_MOD, "home slot arrived out of sequence")

    // finishing a replacement probe bumps the count by exactly one
    `LPHI_ASSERT_NEXT(a_fill_step, aclk, aresetn, (state_reg == S_RP_PROBE) && rp_found, fill_count_reg == FILL_W'($past(fill_count_reg) + 1'b1), "fill count not advanced on insert")

endmodule

// ===== dv/tb_linear_probe_hash_insert.sv =====
`timescale 1ns / 1ps

module tb_linear_probe_hash_insert;
    import lphi_pkg::*;

    localparam int TS           = TABLE_SIZE_DEF;
    localparam int RANDOM_WORDS = 1884;
    localparam int BACKLOG_AT   = 300;   // random word at which the sink holds off
    localparam int DRAIN_AT     = 1000;  // random word at which the source waits for drain
    localparam int LONG_HOLD    = 400;   // sink hold-off, in cycles
    localparam int TAIL         = 80;    // longer than the slowest insert
    localparam int QUIET_LIMIT  = 4000;  // cycles with no handshake on either side

    // One result word, laid out field by field.
    typedef struct packed {
        status_t         status;
        logic [3:0]      plain_slot;
        logic [3:0]      repl_slot;
        logic            displaced;
        logic            plain_valid;
        logic [KEY_W-1:0] plain_value;
        logic            repl_valid;
        logic [KEY_W-1:0] repl_value;
    } result_t;

    // One request word; typed marks rows whose result is written out by hand.
    typedef struct packed {
        req_t             req;
        logic [KEY_W-1:0] key;
        logic [3:0]       idx;
        logic             typed;
        result_t          want;
    } stim_row_t;

    typedef enum logic [1:0] {
        RX_OPEN,    // always ready
        RX_COIN,    // ready half the time
        RX_SPARSE,  // ready one cycle in four
        RX_MOSTLY   // ready with probability 7/8
    } rx_pat_t;

    localparam result_t NO_WANT = '0;

    // Directed script. Typed rows: first words after reset and the key extremes.
    // The rest go through the predictor: native home -> probe, foreign home ->
    // displacement, probe wrapping past the top slot, then reads of what landed.
    localparam int SCRIPT_LEN = 16;
    localparam stim_row_t SCRIPT [SCRIPT_LEN] = '{
        '{REQ_INSERT, 31'd0, 4'hA, 1'b1,
          '{ST_INSERTED, 4'd0, 4'd0, 1'b0, 1'b0, 31'd0, 1'b0, 31'd0}},
        '{REQ_READ, 31'h7FFFFFFF, 4'd0, 1'b1,
          '{ST_READ, 4'd0, 4'd0, 1'b0, 1'b1, 31'd0, 1'b1, 31'd0}},
        '{REQ_INSERT, 31'h7FFFFFFF, 4'd0, 1'b1,
          '{ST_INSERTED, 4'd15, 4'd15, 1'b0, 1'b0, 31'd0, 1'b0, 31'd0}},
        '{REQ_READ, 31'd0, 4'd15, 1'b1,
          '{ST_READ, 4'd0, 4'd0, 1'b0, 1'b1, 31'h7FFFFFFF, 1'b1, 31'h7FFFFFFF}},
        '{REQ_INSERT, 31'd16, 4'd3, 1'b0, NO_WANT},          // home 0 held natively
        '{REQ_INSERT, 31'd1, 4'd0, 1'b0, NO_WANT},           // home 1 held by a guest
        '{REQ_INSERT, 31'd31, 4'd7, 1'b0, NO_WANT},          // probe wraps 15 -> 3
        '{REQ_INSERT, 31'h7FFFFFF2, 4'd0, 1'b0, NO_WANT},    // displaces again
        '{REQ_READ, 31'h12345678, 4'd1, 1'b0, NO_WANT},
        '{REQ_READ, 31'd0, 4'd2, 1'b0, NO_WANT},
        '{REQ_READ, 31'd0, 4'd3, 1'b0, NO_WANT},
        '{REQ_READ, 31'h7FFFFFFF, 4'd4, 1'b0, NO_WANT},
        '{REQ_INSERT, 31'h55555555, 4'hF, 1'b0, NO_WANT},
        '{REQ_INSERT, 31'h2AAAAAAA, 4'h5, 1'b0, NO_WANT},
        '{REQ_READ, 31'd0, 4'd5, 1'b0, NO_WANT},
        '{REQ_READ, 31'h2AAAAAAA, 4'd10, 1'b0, NO_WANT}
    };

    // DUT ports; the inputs are known from time zero.
    logic                  aclk          = 1'b0;
    logic                  aresetn       = 1'b0;
    logic                  s_valid       = 1'b0;
    logic                  s_ready;
    logic                  s_req_type    = 1'b0;
    logic [KEY_W-1:0]      s_key         = '0;
    logic [SLOT_OUT_W-1:0] s_slot_index  = '0;
    logic                  m_valid;
    logic                  m_ready       = 1'b0;
    logic [STATUS_W-1:0]   m_status;
    logic [SLOT_OUT_W-1:0] m_plain_slot;
    logic [SLOT_OUT_W-1:0] m_repl_slot;
    logic                  m_displaced;
    logic                  m_plain_valid;
    logic [KEY_W-1:0]      m_plain_value;
    logic                  m_repl_valid;
    logic [KEY_W-1:0]      m_repl_value;

    // Predictor state: shadow copies of both tables and the insert count.
    logic [KEY_W-1:0] plain_tab [TS];
    logic [TS-1:0]    plain_taken;
    logic [KEY_W-1:0] swap_tab [TS];
    logic [TS-1:0]    swap_taken;
    int               keys_held;

    result_t due_results [$];     // results still owed by the block, oldest first
    result_t head_due;
    bit      all_ok;
    int      mismatches   = 0;
    int      quiet_cycles = 0;
    int      burst_left;
    bit      backlog_req  = 1'b0;  // source asks the sink for its long hold-off
    bit      backlog_done = 1'b0;

    linear_probe_hash_insert dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_req_type    (s_req_type),
        .s_key         (s_key),
        .s_slot_index  (s_slot_index),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_status      (m_status),
        .m_plain_slot  (m_plain_slot),
        .m_repl_slot   (m_repl_slot),
        .m_displaced   (m_displaced),
        .m_plain_valid (m_plain_valid),
        .m_plain_value (m_plain_value),
        .m_repl_valid  (m_repl_valid),
        .m_repl_value  (m_repl_value)
    );

    always begin
        aclk = 1'b0;
        #5;
        aclk = 1'b1;
        #5;
    end

    // Linear probe: first free slot at or after start, wrapping at the top.
    function automatic int first_free(logic [TS-1:0] taken, int start);
        for (int i = 0; i < TS; i++) begin
            if (!taken[(start + i) % TS]) return (start + i) % TS;
        end
        return start % TS;
    endfunction

    // Result of one word against the shadow tables; inserts update them.
    function automatic result_t place_or_read(req_t req, logic [KEY_W-1:0] key,
                                              logic [3:0] idx);
        result_t          r;
        int               home;
        int               ps;
        int               rs;
        logic [KEY_W-1:0] mover;
        r = '0;
        if (req == REQ_READ) begin
            r.status = ST_READ;
            if (int'(idx) < TS) begin
                if (plain_taken[idx]) begin
                    r.plain_valid = 1'b1;
                    r.plain_value = plain_tab[idx];
                end
                if (swap_taken[idx]) begin
                    r.repl_valid = 1'b1;
                    r.repl_value = swap_tab[idx];
                end
            end
            return r;
        end
        if (keys_held >= TS) begin
            r.status = ST_FULL;
            return r;
        end
        home = int'(key % TS);
        ps = first_free(plain_taken, home);
        plain_tab[ps] = key;
        plain_taken[ps] = 1'b1;
        if (!swap_taken[home]) begin
            rs = home;
            swap_tab[home] = key;
            swap_taken[home] = 1'b1;
        end else begin
            // A native occupant stays put; a guest is pushed out by the newcomer.
            if (int'(swap_tab[home] % TS) == home) begin
                mover = key;
            end else begin
                mover = swap_tab[home];
                swap_tab[home] = key;
                r.displaced = 1'b1;
            end
            rs = first_free(swap_taken, home + 1);
            swap_tab[rs] = mover;
            swap_taken[rs] = 1'b1;
        end
        keys_held++;
        r.status = ST_INSERTED;
        r.plain_slot = 4'(ps);
        r.repl_slot = 4'(rs);
        return r;
    endfunction

    // Random word shaped by table state. While filling, inserts crowd the low
    // homes so probes run long and guests get pushed; reads only touch slots
    // that hold a key in both tables. Once full, inserts bounce and reads roam.
    function automatic stim_row_t next_random();
        stim_row_t        w;
        logic [TS-1:0]    both;
        logic [KEY_W-1:0] k;
        w = '0;
        both = plain_taken & swap_taken;
        k = KEY_W'($urandom);
        w.idx = 4'($urandom_range(0, 15));
        if (keys_held < TS) begin
            if (both != '0 && $urandom_range(0, 9) < 4) begin
                w.req = REQ_READ;
                while (!both[w.idx]) w.idx = 4'($urandom_range(0, 15));
            end else begin
                w.req = REQ_INSERT;
                if ($urandom_range(0, 3) != 0) k[3:0] = 4'($urandom_range(0, 3));
            end
        end else begin
            w.req = $urandom_range(0, 1) ? REQ_READ : REQ_INSERT;
        end
        w.key = k;
        return w;
    endfunction

    // Present one word, hold it until taken, then book its result.
    task automatic offer_word(input stim_row_t w);
        result_t r;
        s_valid      <= 1'b1;
        s_req_type   <= w.req;
        s_key        <= w.key;
        s_slot_index <= w.idx;
        do @(posedge aclk); while (!s_ready);
        r = place_or_read(w.req, w.key, w.idx);
        due_results.push_back(w.typed ? w.want : r);
    endtask

    // Source pacing: bursts of back-to-back words, random gaps between them.
    task automatic space_out();
        burst_left--;
        if (burst_left <= 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge aclk);
            burst_left = $urandom_range(1, 40);
        end
    endtask

    // Source goes quiet until the block has handed back everything owed.
    task automatic drain();
        s_valid <= 1'b0;
        do @(posedge aclk); while (due_results.size() != 0);
    endtask

    function automatic bit field_ok(string name, logic [KEY_W-1:0] want,
                                    logic [KEY_W-1:0] got);
        if (got !== want) begin
            $display("%0t: %s expected %0h got %0h", $time, name, want, got);
            return 1'b0;
        end
        return 1'b1;
    endfunction

    // Source: reset, directed script, random words, then wait out the tail.
    initial begin
        plain_taken = '0;
        swap_taken  = '0;
        keys_held   = 0;
        burst_left  = $urandom_range(1, 40);
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        for (int n = 0; n < SCRIPT_LEN; n++) begin
            offer_word(SCRIPT[n]);
            space_out();
        end
        for (int n = 0; n < RANDOM_WORDS; n++) begin
            if (n == BACKLOG_AT) backlog_req = 1'b1;
            if (n == DRAIN_AT) drain();
            offer_word(next_random());
            space_out();
        end
        s_valid <= 1'b0;
        do @(posedge aclk); while (due_results.size() != 0);
        repeat (TAIL) @(posedge aclk);
        if (due_results.size() != 0) begin
            $display("%0t: %0d results never arrived", $time, due_results.size());
            mismatches++;
        end
        if (mismatches == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

    // Sink: switches between ready patterns; once, on request, holds m_ready low
    // for the long hold-off so the result register and the input both back up.
    initial begin
        rx_pat_t pat;
        int      pat_left;
        pat = RX_OPEN;
        pat_left = 0;
        forever begin
            @(posedge aclk);
            if (backlog_req && !backlog_done) begin
                m_ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge aclk);
                backlog_done = 1'b1;
            end
            if (pat_left == 0) begin
                pat = rx_pat_t'($urandom_range(0, 3));
                pat_left = $urandom_range(20, 200);
            end
            pat_left--;
            case (pat)
                RX_OPEN:   m_ready <= 1'b1;
                RX_COIN:   m_ready <= 1'($urandom_range(0, 1));
                RX_SPARSE: m_ready <= ($urandom_range(0, 3) == 0);
                default:   m_ready <= ($urandom_range(0, 7) != 0);
            endcase
        end
    end

    // Result check: every word taken is matched against the oldest one owed.
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (due_results.size() == 0) begin
                $display("%0t: result with none due, status expected none got %0h",
                         $time, m_status);
                mismatches++;
            end else begin
                head_due = due_results.pop_front();
                all_ok = field_ok("status", KEY_W'(head_due.status), KEY_W'(m_status));
                all_ok &= field_ok("plain_slot", KEY_W'(head_due.plain_slot),
                                   KEY_W'(m_plain_slot));
                all_ok &= field_ok("repl_slot", KEY_W'(head_due.repl_slot),
                                   KEY_W'(m_repl_slot));
                all_ok &= field_ok("displaced", KEY_W'(head_due.displaced),
                                   KEY_W'(m_displaced));
                all_ok &= field_ok("plain_valid", KEY_W'(head_due.plain_valid),
                                   KEY_W'(m_plain_valid));
                all_ok &= field_ok("plain_value", head_due.plain_value, m_plain_value);
                all_ok &= field_ok("repl_valid", KEY_W'(head_due.repl_valid),
                                   KEY_W'(m_repl_valid));
                all_ok &= field_ok("repl_value", head_due.repl_value, m_repl_value);
                if (!all_ok) mismatches++;
            end
        end
    end

    // Watchdog: too long with no handshake on either channel ends the run.
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= QUIET_LIMIT) begin
                $display("%0t: no handshake for %0d cycles", $time, quiet_cycles);
                $display("== FAIL ==");
                $finish;
            end
        end
    end

endmodule
